### sv/assert_macros.svh
// Assertion macros shared by the table interpolation RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define PLTI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check that a condition never holds outside reset.
`define PLTI_ASSERT_NEVER(label, expr, msg) \
    `PLTI_ASSERT(label, !(expr), msg)

`endif

### sv/plti_pkg.sv
// Types, constants and helper functions for the table interpolation unit.
package plti_pkg;

    localparam int MAX_POINTS = 16;
    localparam int PIDX_W     = $clog2(MAX_POINTS);
    localparam int PC_W       = 5;
    localparam int DATA_W     = 16;
    localparam int DIV_CNT_W  = $clog2(DATA_W);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int Q_DEPTH    = 2;
    localparam int QPTR_W     = $clog2(Q_DEPTH);
    localparam int QCNT_W     = QPTR_W + 1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POINT_COUNT  = 2'd0,
        CFG_AXIS_SIGNED  = 2'd1,
        CFG_VALUE_SIGNED = 2'd2
    } t_cfg_index;

    // Function codes of an input request
    typedef enum logic {
        FUNC_WRITE  = 1'b0,
        FUNC_LOOKUP = 1'b1
    } t_func;

    // Request as held in the queue; a_word is the axis point on a write and
    // the ordered query key on a lookup.
    typedef struct packed {
        t_func               kind;
        logic [PIDX_W-1:0]   idx;
        logic [DATA_W-1:0]   a_word;
        logic [DATA_W-1:0]   b_word;
    } t_req;

    // Divider start request and response
    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] ydiff;
        logic [DATA_W-1:0] du;
        logic [DATA_W-1:0] span;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quot;
    } t_div_rsp;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_MUL,
        DIV_ITER
    } t_div_phase;

    typedef enum logic [2:0] {
        B_IDLE,
        B_LOW,
        B_HIGH,
        B_SCAN,
        B_DIV,
        B_DONE
    } t_back_state;

    // Map a 16 bit pattern to an unsigned key that orders it per the mode.
    function automatic logic [DATA_W-1:0] order_key(input logic [DATA_W-1:0] v,
                                                     input logic is_signed);
        return {v[DATA_W-1] ^ is_signed, v[DATA_W-2:0]};
    endfunction

    // Index of the last breakpoint in use: zero counts as one, large saturates.
    function automatic logic [PIDX_W-1:0] last_index(input logic [PC_W-1:0] pc);
        logic [PIDX_W-1:0] res;
        if (pc == '0) begin
            res = '0;
        end else if (pc > PC_W'(MAX_POINTS)) begin
            res = PIDX_W'(MAX_POINTS - 1);
        end else begin
            res = PIDX_W'(pc - PC_W'(1));
        end
        return res;
    endfunction

endpackage

### sv/plti_front.sv
// Front part: accepts requests, classifies them and queues them for the back part.
`include "assert_macros.svh"

module plti_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_axis_signed,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic                    i_func,
    input  logic [3:0]              i_point_index,
    input  logic [15:0]             i_axis_point,
    input  logic [15:0]             i_value_point,
    input  logic [15:0]             i_query,
    output logic                    o_req_valid,
    output plti_pkg::t_req          o_req,
    input  logic                    i_req_take
);
    import plti_pkg::*;

    t_req              r_queue [Q_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    t_req              new_req;
    logic              push;
    logic              pop;

    // Classify the incoming request and pre-compute the query key
    always_comb begin
        new_req.kind = t_func'(i_func);
        new_req.idx  = PIDX_W'(i_point_index);
        if (new_req.kind == FUNC_LOOKUP) begin
            new_req.a_word = order_key(i_query, i_axis_signed);
        end else begin
            new_req.a_word = i_axis_point;
        end
        new_req.b_word = i_value_point;
    end

    assign o_stall     = (r_cnt == QCNT_W'(Q_DEPTH));
    assign push        = i_valid && !o_stall;
    assign o_req_valid = (r_cnt != '0);
    assign pop         = o_req_valid && i_req_take;
    assign o_req       = r_queue[r_rd_ptr];

    // Advance pointers and count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
        end
        if (push && !pop) begin
            n_cnt = r_cnt + QCNT_W'(1);
        end else if (pop && !push) begin
            n_cnt = r_cnt - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // Store the request in the queue
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= new_req;
        end
    end

    `PLTI_ASSERT(a_cnt_tracks, push && !pop |=> r_cnt == $past(r_cnt) + QCNT_W'(1), "queue count lost a push")
    `PLTI_ASSERT_NEVER(a_cnt_bound, r_cnt > QCNT_W'(Q_DEPTH), "queue count above depth")

endmodule

### sv/plti_div.sv
// Multiply and restoring divide unit computing ydiff * du / span.
`include "assert_macros.svh"

module plti_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  plti_pkg::t_div_req  i_req,
    output plti_pkg::t_div_rsp  o_rsp
);
    import plti_pkg::*;

    t_div_phase           r_phase, n_phase;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [DATA_W-1:0]    r_a, r_b, r_span;
    logic [DATA_W-1:0]    r_rem, n_rem;
    logic [DATA_W-1:0]    r_quo, n_quo;
    logic [DATA_W:0]      trial;
    logic [DATA_W:0]      diff;
    logic [2*DATA_W-1:0]  prod;

    assign prod  = r_a * r_b;
    assign trial = {r_rem, r_quo[DATA_W-1]};
    assign diff  = trial - {1'b0, r_span};

    // Step the sequencer: a multiply step, then one quotient bit per cycle
    always_comb begin
        n_phase = r_phase;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_quo   = r_quo;
        unique case (r_phase)
            DIV_IDLE: begin
                if (i_req.start) begin
                    n_phase = DIV_MUL;
                end
            end
            DIV_MUL: begin
                // product upper half is below span, so 16 steps suffice
                n_rem   = prod[2*DATA_W-1:DATA_W];
                n_quo   = prod[DATA_W-1:0];
                n_cnt   = DIV_CNT_W'(DATA_W - 1);
                n_phase = DIV_ITER;
            end
            DIV_ITER: begin
                if (trial >= {1'b0, r_span}) begin
                    n_rem = diff[DATA_W-1:0];
                    n_quo = {r_quo[DATA_W-2:0], 1'b1};
                end else begin
                    n_rem = trial[DATA_W-1:0];
                    n_quo = {r_quo[DATA_W-2:0], 1'b0};
                end
                n_cnt = r_cnt - DIV_CNT_W'(1);
                if (r_cnt == '0) begin
                    n_done  = 1'b1;
                    n_phase = DIV_IDLE;
                end
            end
            default: n_phase = DIV_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= DIV_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= n_done;
        end
    end

    // Hold operands and working registers
    always_ff @(posedge i_clk) begin
        if (r_phase == DIV_IDLE && i_req.start) begin
            r_a    <= i_req.ydiff;
            r_b    <= i_req.du;
            r_span <= i_req.span;
        end
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;

    `PLTI_ASSERT(a_done_after_iter, r_done |-> $past(r_phase) == DIV_ITER, "divider done early")

endmodule

### sv/plti_back.sv
// Back part: breakpoint table, segment search, interpolation and result register.
`include "assert_macros.svh"

module plti_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [4:0]              i_point_count,
    input  logic                    i_axis_signed,
    input  logic                    i_value_signed,
    input  logic                    i_req_valid,
    input  plti_pkg::t_req          i_req,
    output logic                    o_req_take,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [15:0]             o_result
);
    import plti_pkg::*;

    // Table memory: axis point in the upper half, value in the lower half
    logic [2*DATA_W-1:0] r_mem [MAX_POINTS];
    logic [2*DATA_W-1:0] r_rd_data;
    logic [PIDX_W-1:0]   rd_addr;
    logic                mem_we;

    t_back_state         r_state, n_state;
    logic [PIDX_W-1:0]   r_idx, n_idx;
    logic [DATA_W-1:0]   r_qkey, n_qkey;
    logic [DATA_W-1:0]   r_prev_axis, n_prev_axis;
    logic [DATA_W-1:0]   r_prev_value, n_prev_value;
    logic [DATA_W-1:0]   r_y0, n_y0;
    logic                r_down, n_down;
    logic [DATA_W-1:0]   r_res, n_res;
    logic                r_out_valid, n_out_valid;
    logic [DATA_W-1:0]   r_out_result, n_out_result;

    logic [DATA_W-1:0]   rd_axis, rd_value;
    logic [DATA_W-1:0]   k0, k1, yk0, yk1;
    logic [PIDX_W-1:0]   idx_last;
    logic                out_free;
    t_div_req            div_req;
    t_div_rsp            div_rsp;

    assign rd_axis  = r_rd_data[2*DATA_W-1:DATA_W];
    assign rd_value = r_rd_data[DATA_W-1:0];
    assign k0       = order_key(r_prev_axis, i_axis_signed);
    assign k1       = order_key(rd_axis, i_axis_signed);
    assign yk0      = order_key(r_prev_value, i_value_signed);
    assign yk1      = order_key(rd_value, i_value_signed);
    assign idx_last = last_index(i_point_count);
    assign out_free = !r_out_valid || !i_stall;

    plti_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Sequence one request: a table write, or for a lookup clamp checks, segment scan, interpolation
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_qkey       = r_qkey;
        n_prev_axis  = r_prev_axis;
        n_prev_value = r_prev_value;
        n_y0         = r_y0;
        n_down       = r_down;
        n_res        = r_res;
        n_out_valid  = r_out_valid && i_stall;
        n_out_result = r_out_result;
        rd_addr      = '0;
        mem_we       = 1'b0;
        o_req_take   = 1'b0;
        div_req      = '0;
        unique case (r_state)
            B_IDLE: begin
                if (i_req_valid) begin
                    o_req_take = 1'b1;
                    if (i_req.kind == FUNC_WRITE) begin
                        mem_we = 1'b1;
                    end else begin
                        n_qkey  = i_req.a_word;
                        n_state = B_LOW;
                    end
                end
            end
            B_LOW: begin
                // below the first breakpoint: first value
                if (r_qkey < k1) begin
                    n_res   = rd_value;
                    n_state = B_DONE;
                end else begin
                    n_prev_axis  = rd_axis;
                    n_prev_value = rd_value;
                    rd_addr      = idx_last;
                    n_state      = B_HIGH;
                end
            end
            B_HIGH: begin
                // at or above the last breakpoint: last value
                if (r_qkey >= k1) begin
                    n_res   = rd_value;
                    n_state = B_DONE;
                end else begin
                    rd_addr = PIDX_W'(1);
                    n_idx   = PIDX_W'(1);
                    n_state = B_SCAN;
                end
            end
            B_SCAN: begin
                if (r_qkey == k1 && k0 == k1) begin
                    // query on a step: lower-index value
                    n_res   = r_prev_value;
                    n_state = B_DONE;
                end else if (r_qkey < k1) begin
                    if (r_qkey < k0) begin
                        n_res   = r_prev_value;
                        n_state = B_DONE;
                    end else begin
                        div_req.start = 1'b1;
                        div_req.ydiff = (yk1 < yk0) ? (yk0 - yk1) : (yk1 - yk0);
                        div_req.du    = r_qkey - k0;
                        div_req.span  = k1 - k0;
                        n_down        = (yk1 < yk0);
                        n_y0          = r_prev_value;
                        n_state       = B_DIV;
                    end
                end else begin
                    n_prev_axis  = rd_axis;
                    n_prev_value = rd_value;
                    n_idx        = r_idx + PIDX_W'(1);
                    rd_addr      = r_idx + PIDX_W'(1);
                end
            end
            B_DIV: begin
                if (div_rsp.done) begin
                    n_res   = r_down ? (r_y0 - div_rsp.quot) : (r_y0 + div_rsp.quot);
                    n_state = B_DONE;
                end
            end
            B_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_result = r_res;
                    n_state      = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_qkey       <= n_qkey;
        r_prev_axis  <= n_prev_axis;
        r_prev_value <= n_prev_value;
        r_y0         <= n_y0;
        r_down       <= n_down;
        r_res        <= n_res;
        r_out_result <= n_out_result;
    end

    // Write a breakpoint and read one entry per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[i_req.idx] <= {i_req.a_word, i_req.b_word};
        end
        r_rd_data <= r_mem[rd_addr];
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out_result;

    `PLTI_ASSERT_NEVER(a_done_outside_div, div_rsp.done && r_state != B_DIV, "divider finished outside divide state")
    `PLTI_ASSERT(a_hold_done, r_state == B_DONE && r_out_valid && i_stall |=> r_state == B_DONE, "result dropped while output full")

endmodule

### sv/piecewise_linear_table_interp_unit.sv
// Top level of the piecewise linear table interpolation unit.
// A write request (func 0) stores one axis/value breakpoint in the back part and gives
// no result; a lookup request (func 1) returns one result, the first or last value when
// the query clamps at either end of the table and a value from the matching segment
// otherwise. Its time is set by the segment scan, which reads one breakpoint per cycle
// from the table memory, and by the interpolation unit, which performs a 16 by 16
// multiply followed by a restoring divide. A two-entry request queue and a result
// register let the input and output sides stall independently.
module piecewise_linear_table_interp_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_func,
    input  logic [3:0]  i_point_index,
    input  logic [15:0] i_axis_point,
    input  logic [15:0] i_value_point,
    input  logic [15:0] i_query,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_result,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [4:0]  i_cfg_data
);
    import plti_pkg::*;

    logic [PC_W-1:0] r_point_count;
    logic            r_axis_signed;
    logic            r_value_signed;
    logic            req_valid;
    logic            req_take;
    t_req            req;

    assign o_cfg_ready = 1'b1;

    // Decode configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count  <= PC_W'(2);
            r_axis_signed  <= 1'b0;
            r_value_signed <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_POINT_COUNT:  r_point_count  <= i_cfg_data;
                CFG_AXIS_SIGNED:  r_axis_signed  <= i_cfg_data[0];
                CFG_VALUE_SIGNED: r_value_signed <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    plti_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_axis_signed (r_axis_signed),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_func        (i_func),
        .i_point_index (i_point_index),
        .i_axis_point  (i_axis_point),
        .i_value_point (i_value_point),
        .i_query       (i_query),
        .o_req_valid   (req_valid),
        .o_req         (req),
        .i_req_take    (req_take)
    );

    plti_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_point_count  (r_point_count),
        .i_axis_signed  (r_axis_signed),
        .i_value_signed (r_value_signed),
        .i_req_valid    (req_valid),
        .i_req          (req),
        .o_req_take     (req_take),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_result       (o_result)
    );

endmodule
